/* hw/rtl/dbgdf_pkg.sv */
// ----------------------------------------------------------------------------
// dbgdf_pkg
// shared constants, types and helpers of the debug packet deframer
// ----------------------------------------------------------------------------
package dbgdf_pkg;

    // width of the internal payload counter
    localparam int LENGTH_BITS = 16;
    // width of the packet_length field on the result word
    localparam int LEN_OUT_BITS = 16;
    localparam int LEN_EXT_BITS = (LENGTH_BITS > LEN_OUT_BITS) ? LENGTH_BITS : LEN_OUT_BITS;

    // frame phases
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_CKHI    = 2'd2;
    localparam logic [1:0] PH_CKLO    = 2'd3;

    // result kinds
    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_DATA  = 3'd1;
    localparam logic [2:0] KIND_GOOD  = 3'd2;
    localparam logic [2:0] KIND_BAD   = 3'd3;
    localparam logic [2:0] KIND_ERROR = 3'd4;

    // framing characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_BREAK  = 8'h03;

    typedef struct packed {
        logic [1:0]             phase;
        logic [7:0]             running_sum;
        logic [LENGTH_BITS-1:0] payload_count;
        logic [3:0]             high_nibble;
    } t_state;

    typedef struct packed {
        logic [2:0]              kind;
        logic [7:0]              data_byte;
        logic [LEN_OUT_BITS-1:0] packet_length;
        logic [7:0]              computed_sum;
        logic [7:0]              received_sum;
    } t_result;

    // ascii hex digit to nibble, anything else decodes as zero
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            v = 4'(c[2:0] + 3'd1) + 4'd8;
        end
        return v;
    endfunction

    // counter shown on the result word, saturated to the field width
    function automatic logic [LEN_OUT_BITS-1:0] len_show(input logic [LENGTH_BITS-1:0] c);
        logic [LEN_EXT_BITS-1:0] w;
        logic [LEN_OUT_BITS-1:0] r;
        w = LEN_EXT_BITS'(c);
        if (w > LEN_EXT_BITS'({LEN_OUT_BITS{1'b1}})) begin
            r = '1;
        end else begin
            r = w[LEN_OUT_BITS-1:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/debug_packet_deframer_unit.sv */
// ----------------------------------------------------------------------------
// debug_packet_deframer_unit
// deframes '$' payload '#' hh debugger packets from a byte stream
// ----------------------------------------------------------------------------
// an accepted input word passes the input register, then the result register
// throughput: one word per cycle while the receiver takes every result word, one result word for every input word
// the input register and the result register each refill in the cycle they empty
// reset (i_rst_n low, synchronous) empties both registers and returns the
// frame to idle with sum, length and checksum nibble at zero
module debug_packet_deframer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] data_byte, [23:8] packet_length,
                                        // [31:24] computed_sum, [39:32] received_sum
    output logic [2:0]  m_axis_tuser    // [2:0] kind
);
    import dbgdf_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // frame state
    t_state     r_state;
    t_state     n_state;

    // result register
    logic       r_out_valid;
    t_result    r_out;
    t_result    n_out;

    logic       adv;        // input word moves into the result register
    logic       s_accept;

    // the result register frees up when empty or when it is taken this cycle
    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    dbgdf_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // frame state advances once per word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_IDLE, running_sum: 8'd0,
                         payload_count: '0, high_nibble: 4'd0};
        end else if (adv) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {r_out.received_sum, r_out.computed_sum,
                            r_out.packet_length, r_out.data_byte};

    // a good verdict only when the decoded checksum matches the sum
    a_good_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == KIND_GOOD |-> r_out.received_sum == r_out.computed_sum)
        else $error("good packet with mismatched checksum");

    // a bad verdict only when they differ
    a_bad_differs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == KIND_BAD |-> r_out.received_sum != r_out.computed_sum)
        else $error("bad checksum verdict with matching sums");

    // a payload byte always leaves a nonzero length
    a_data_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == KIND_DATA |-> r_out.packet_length != '0)
        else $error("payload byte with zero packet length");

    // packet start clears the sum and count and enters the payload phase
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_state.phase == PH_IDLE && r_in_byte == CH_DOLLAR
        |=> r_state.phase == PH_PAYLOAD && r_state.running_sum == 8'd0
            && r_state.payload_count == '0)
        else $error("packet start did not reset frame state");

    // checksum phases always emit a verdict word on the second digit
    a_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_state.phase == PH_CKLO
        |=> r_out_valid && (r_out.kind == KIND_GOOD || r_out.kind == KIND_BAD)
            && r_state.phase == PH_IDLE)
        else $error("second checksum digit without verdict");

endmodule

/* hw/rtl/dbgdf_step.sv */
// ----------------------------------------------------------------------------
// dbgdf_step
// next-state and result logic for one received byte
// ----------------------------------------------------------------------------
module dbgdf_step (
    input  dbgdf_pkg::t_state  i_state,
    input  logic [7:0]         i_byte,
    output dbgdf_pkg::t_state  o_state,
    output dbgdf_pkg::t_result o_result
);
    import dbgdf_pkg::*;

    t_state     n_st;
    logic [2:0] kind;
    logic [7:0] rsum;

    always_comb begin
        n_st = i_state;
        kind = KIND_NONE;
        rsum = 8'd0;
        unique case (i_state.phase)
            PH_IDLE: begin
                if (i_byte == CH_DOLLAR) begin
                    n_st.running_sum   = 8'd0;
                    n_st.payload_count = '0;
                    n_st.phase         = PH_PAYLOAD;
                end else if (i_byte == CH_PLUS || i_byte == CH_MINUS
                             || i_byte == CH_BREAK) begin
                    kind = KIND_NONE;
                end else begin
                    kind = KIND_ERROR;
                end
            end
            PH_PAYLOAD: begin
                if (i_byte == CH_HASH) begin
                    n_st.phase = PH_CKHI;
                end else begin
                    n_st.running_sum = i_state.running_sum + i_byte;
                    if (i_state.payload_count != '1) begin
                        n_st.payload_count = i_state.payload_count + 1'b1;
                    end
                    kind = KIND_DATA;
                end
            end
            PH_CKHI: begin
                n_st.high_nibble = hex_value(i_byte);
                n_st.phase       = PH_CKLO;
            end
            PH_CKLO: begin
                rsum       = {i_state.high_nibble, hex_value(i_byte)};
                kind       = (rsum == i_state.running_sum) ? KIND_GOOD : KIND_BAD;
                n_st.phase = PH_IDLE;
            end
            default: begin
                n_st.phase = PH_IDLE;
            end
        endcase
    end

    assign o_state                = n_st;
    assign o_result.kind          = kind;
    assign o_result.data_byte     = i_byte;
    assign o_result.packet_length = len_show(n_st.payload_count);
    assign o_result.computed_sum  = n_st.running_sum;
    assign o_result.received_sum  = rsum;

endmodule

/* tb/tb_debug_packet_deframer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_debug_packet_deframer_unit
// self-checking bench: a directed script of framing corner cases, then random
// packets mixed with ack bytes, stray bytes and cut-off frames, all under
// random sender bursts and receiver back-pressure, with every result word
// checked against a pinned script value or a behavioral deframer kept in the bench
// ----------------------------------------------------------------------------
module tb_debug_packet_deframer_unit;
    import dbgdf_pkg::*;

    localparam int RANDOM_WORDS  = 650;
    localparam int MAX_PRINTS    = 50;
    localparam int DRAIN_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 6;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;     // [7:0] in_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;             // [7:0] data_byte, [23:8] packet_length,
                                           // [31:24] computed_sum, [39:32] received_sum
    logic [2:0]  m_axis_tuser;             // [2:0] kind

    debug_packet_deframer_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // bench copy of the frame state
    // ------------------------------------------------------------------
    logic [1:0]             frame_phase = PH_IDLE;
    logic [7:0]             frame_sum   = 8'h00;
    logic [LENGTH_BITS-1:0] frame_count = '0;
    logic [3:0]             ck_high     = 4'h0;

    t_result pending_results [$];

    int mismatches    = 0;
    int words_sent    = 0;
    int framed_words  = 0;
    int results_seen  = 0;
    int good_seen     = 0;
    int bad_seen      = 0;
    int error_seen    = 0;
    int payload_seen  = 0;
    int burst_left    = 0;

    // ascii hex digit to nibble, anything else counts as zero
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [3:0] n;
        n = 4'h0;
        if (c >= "0" && c <= "9") n = 4'(c - "0");
        else if (c >= "a" && c <= "f") n = 4'(c - "a" + 10);
        else if (c >= "A" && c <= "F") n = 4'(c - "A" + 10);
        return n;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        logic [7:0] c;
        if (n < 4'd10) c = 8'("0") + 8'(n);
        else c = (upper ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
        return c;
    endfunction

    // advances the bench frame state by one byte and returns the result word
    function automatic t_result deframe_byte(input logic [7:0] c);
        t_result r;
        logic [7:0] ck;
        r = '0;
        ck = 8'h00;
        r.kind = KIND_NONE;
        case (frame_phase)
            PH_IDLE: begin
                if (c == CH_DOLLAR) begin
                    frame_sum   = 8'h00;
                    frame_count = '0;
                    frame_phase = PH_PAYLOAD;
                end else if (c != CH_PLUS && c != CH_MINUS && c != CH_BREAK) begin
                    r.kind = KIND_ERROR;
                end
            end
            PH_PAYLOAD: begin
                if (c == CH_HASH) begin
                    frame_phase = PH_CKHI;
                end else begin
                    frame_sum = frame_sum + c;
                    // counter holds at all ones
                    if (frame_count != {LENGTH_BITS{1'b1}}) frame_count = frame_count + 1'b1;
                    r.kind = KIND_DATA;
                end
            end
            PH_CKHI: begin
                ck_high     = nibble_of(c);
                frame_phase = PH_CKLO;
            end
            default: begin
                ck          = {ck_high, nibble_of(c)};
                r.kind      = (ck == frame_sum) ? KIND_GOOD : KIND_BAD;
                frame_phase = PH_IDLE;
            end
        endcase
        r.data_byte     = c;
        r.packet_length = (64'(frame_count) > 64'hFFFF) ? 16'hFFFF : 16'(frame_count);
        r.computed_sum  = frame_sum;
        r.received_sum  = ck;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (mismatches < MAX_PRINTS)
            $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // sender: bursts of random length with random gaps in between
    // ------------------------------------------------------------------
    task automatic send_word(input logic [7:0] c, input bit pinned, input t_result pinned_res);
        int gap;
        t_result predicted;
        if (burst_left == 0) begin
            // about a third of the bursts run straight into the next one
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
        words_sent++;
        if (c != CH_PLUS && c != CH_MINUS && c != CH_BREAK) framed_words++;
        predicted = deframe_byte(c);
        pending_results.push_back(pinned ? pinned_res : predicted);
    endtask

    task automatic send_plain(input logic [7:0] c);
        send_word(c, 1'b0, '0);
    endtask

    // one framed packet: mostly a correct checksum, sometimes a wrong one,
    // sometimes arbitrary bytes in the checksum digits
    task automatic send_packet(input int len);
        logic [7:0] sum;
        logic [7:0] c;
        logic [7:0] ck;
        int i;
        int pick;
        sum = 8'h00;
        send_plain(CH_DOLLAR);
        for (i = 0; i < len; i++) begin
            c = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 9) == 0) c = CH_DOLLAR;
            if (c == CH_HASH) c = 8'h00;
            sum = sum + c;
            send_plain(c);
        end
        send_plain(CH_HASH);
        pick = $urandom_range(0, 19);
        if (pick < 17) begin
            ck = (pick < 14) ? sum : sum ^ (8'h01 << $urandom_range(0, 7));
            send_plain(hex_char(ck[7:4], $urandom_range(0, 1)));
            send_plain(hex_char(ck[3:0], $urandom_range(0, 1)));
        end else begin
            send_plain(8'($urandom_range(0, 255)));
            send_plain(8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------
    // receiver: back-pressure modes that change every so often
    // ------------------------------------------------------------------
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_TWO_OF_THREE, RX_TRICKLE} t_rx_mode;
    t_rx_mode ready_mode = RX_OPEN;
    int       mode_left  = 0;
    int       stall_tick = 0;

    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode <= t_rx_mode'($urandom_range(0, 3));
            mode_left  <= $urandom_range(16, 160);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            RX_OPEN:         m_axis_tready <= 1'b1;
            RX_COIN:         m_axis_tready <= 1'($urandom_range(0, 1));
            RX_TWO_OF_THREE: m_axis_tready <= (stall_tick % 3) != 0;
            default:         m_axis_tready <= (stall_tick % 7) == 0;
        endcase
        stall_tick <= stall_tick + 1;
    end

    // ------------------------------------------------------------------
    // result checker: every accepted word against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            case (m_axis_tuser)
                KIND_DATA:  payload_seen++;
                KIND_GOOD:  good_seen++;
                KIND_BAD:   bad_seen++;
                KIND_ERROR: error_seen++;
                default:    ;
            endcase
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result word", 16'(m_axis_tdata[7:0]), 16'h0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser != want.kind)
                    report_mismatch("kind", 16'(m_axis_tuser), 16'(want.kind));
                if (m_axis_tdata[7:0] != want.data_byte)
                    report_mismatch("data_byte", 16'(m_axis_tdata[7:0]), 16'(want.data_byte));
                if (m_axis_tdata[23:8] != want.packet_length)
                    report_mismatch("packet_length", m_axis_tdata[23:8], want.packet_length);
                if (m_axis_tdata[31:24] != want.computed_sum)
                    report_mismatch("computed_sum", 16'(m_axis_tdata[31:24]),
                                    16'(want.computed_sum));
                if (m_axis_tdata[39:32] != want.received_sum)
                    report_mismatch("received_sum", 16'(m_axis_tdata[39:32]),
                                    16'(want.received_sum));
            end
        end
    end

    // ------------------------------------------------------------------
    // directed script: bytes with the result pinned where it is obvious
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [7:0]  c;
        bit          pinned;
        logic [2:0]  kind;
        logic [15:0] len;
        logic [7:0]  sum;
        logic [7:0]  rsum;
    } t_script_row;

    localparam int SCRIPT_ROWS = 27;

    t_script_row script_rows [SCRIPT_ROWS] = '{
        // idle: zero byte and all-ones are protocol errors, acks are dropped
        '{8'h00,     1'b1, KIND_ERROR, 16'd0, 8'h00, 8'h00},
        '{CH_PLUS,   1'b1, KIND_NONE,  16'd0, 8'h00, 8'h00},
        '{CH_MINUS,  1'b1, KIND_NONE,  16'd0, 8'h00, 8'h00},
        '{CH_BREAK,  1'b1, KIND_NONE,  16'd0, 8'h00, 8'h00},
        '{8'hFF,     1'b1, KIND_ERROR, 16'd0, 8'h00, 8'h00},
        // empty packet "$#00"
        '{CH_DOLLAR, 1'b1, KIND_NONE,  16'd0, 8'h00, 8'h00},
        '{CH_HASH,   1'b1, KIND_NONE,  16'd0, 8'h00, 8'h00},
        '{8'h30,     1'b1, KIND_NONE,  16'd0, 8'h00, 8'h00},
        '{8'h30,     1'b1, KIND_GOOD,  16'd0, 8'h00, 8'h00},
        // dollar inside the payload, sum wraps past 0xff
        '{CH_DOLLAR, 1'b0, KIND_NONE,  16'd0, 8'h00, 8'h00},
        '{8'h61,     1'b1, KIND_DATA,  16'd1, 8'h61, 8'h00},
        '{CH_DOLLAR, 1'b1, KIND_DATA,  16'd2, 8'h85, 8'h00},
        '{8'hFF,     1'b1, KIND_DATA,  16'd3, 8'h84, 8'h00},
        '{CH_HASH,   1'b0, KIND_NONE,  16'd0, 8'h00, 8'h00},
        '{8'h38,     1'b0, KIND_NONE,  16'd0, 8'h00, 8'h00},
        '{8'h34,     1'b1, KIND_GOOD,  16'd3, 8'h84, 8'h84},
        // zero payload byte, non-hex digits decode as zero
        '{CH_DOLLAR, 1'b0, KIND_NONE,  16'd0, 8'h00, 8'h00},
        '{8'h00,     1'b1, KIND_DATA,  16'd1, 8'h00, 8'h00},
        '{CH_HASH,   1'b0, KIND_NONE,  16'd0, 8'h00, 8'h00},
        '{8'h47,     1'b0, KIND_NONE,  16'd0, 8'h00, 8'h00},
        '{8'h5A,     1'b1, KIND_GOOD,  16'd1, 8'h00, 8'h00},
        // bad checksum with mixed-case digits
        '{CH_DOLLAR, 1'b0, KIND_NONE,  16'd0, 8'h00, 8'h00},
        '{8'h78,     1'b0, KIND_NONE,  16'd0, 8'h00, 8'h00},
        '{CH_HASH,   1'b0, KIND_NONE,  16'd0, 8'h00, 8'h00},
        '{8'h46,     1'b0, KIND_NONE,  16'd0, 8'h00, 8'h00},
        '{8'h66,     1'b1, KIND_BAD,   16'd1, 8'h78, 8'hFF},
        // after a packet the finished sum and length stay visible
        '{8'h37,     1'b1, KIND_ERROR, 16'd1, 8'h78, 8'h00}
    };

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        t_result pinned_res;
        int r;
        int i;
        int n;
        int pick;
        int len;
        int random_start;
        int drain;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < SCRIPT_ROWS; r++) begin
            pinned_res               = '0;
            pinned_res.kind          = script_rows[r].kind;
            pinned_res.data_byte     = script_rows[r].c;
            pinned_res.packet_length = script_rows[r].len;
            pinned_res.computed_sum  = script_rows[r].sum;
            pinned_res.received_sum  = script_rows[r].rsum;
            send_word(script_rows[r].c, script_rows[r].pinned, pinned_res);
        end

        random_start = framed_words;
        while (framed_words - random_start < RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                n = $urandom_range(0, 99);
                if (n < 70)      len = $urandom_range(0, 8);
                else if (n < 95) len = $urandom_range(9, 40);
                else             len = $urandom_range(41, 300);
                send_packet(len);
            end else if (pick < 80) begin
                // ack and break bytes between packets
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++) begin
                    case ($urandom_range(0, 2))
                        0:       send_plain(CH_PLUS);
                        1:       send_plain(CH_MINUS);
                        default: send_plain(CH_BREAK);
                    endcase
                end
            end else if (pick < 90) begin
                // line noise, any byte value
                n = $urandom_range(1, 4);
                for (i = 0; i < n; i++) send_plain(8'($urandom_range(0, 255)));
            end else begin
                // frame cut off somewhere, the next bytes land inside it
                send_plain(CH_DOLLAR);
                n = $urandom_range(0, 3);
                for (i = 0; i < n; i++) send_plain(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) == 1) begin
                    send_plain(CH_HASH);
                    send_plain(hex_char(4'($urandom_range(0, 15)), 1'b0));
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain, then keep watching for stray words
        drain = 0;
        while (pending_results.size() > 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_results.size() > 0)
            report_mismatch("results never delivered", 16'(pending_results.size()), 16'h0);

        $display("run covered %0d input words and %0d result words: %0d payload bytes,",
                 words_sent, results_seen, payload_seen);
        $display("%0d good packets, %0d bad checksums, %0d protocol errors, %0d mismatches",
                 good_seen, bad_seen, error_seen, mismatches);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/dbgdf_pkg.sv
hw/rtl/dbgdf_step.sv
hw/rtl/debug_packet_deframer_unit.sv
tb/tb_debug_packet_deframer_unit.sv
